// ===== design/rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtp_pkg: shared codes for the record trim and pad block
// operation, region, status and configuration register index codes
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

	// operation codes
	localparam logic [2:0] OP_CUT         = 3'd0;
	localparam logic [2:0] OP_LEAVE       = 3'd1;
	localparam logic [2:0] OP_ZERO_FILL   = 3'd2;
	localparam logic [2:0] OP_EXTRAPOLATE = 3'd3;
	// first unsupported code, loaded at reset
	localparam logic [2:0] OP_UNDEFINED   = 3'd4;

	// region codes
	localparam logic [1:0] RG_HEAD      = 2'd0;
	localparam logic [1:0] RG_TAIL      = 2'd1;
	localparam logic [1:0] RG_BOTH      = 2'd2;
	localparam logic [1:0] RG_UNDEFINED = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_NOTHING      = 3'd1;
	localparam logic [2:0] ST_TOO_MANY     = 3'd2;
	localparam logic [2:0] ST_HEAD_GT_TAIL = 3'd3;
	localparam logic [2:0] ST_PAD_TOO_LONG = 3'd4;
	localparam logic [2:0] ST_UNDEF_OP     = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_OPERATION     = 3'd0;
	localparam logic [2:0] REG_REGION        = 3'd1;
	localparam logic [2:0] REG_HEAD_POINTS   = 3'd2;
	localparam logic [2:0] REG_TAIL_POINTS   = 3'd3;
	localparam logic [2:0] REG_RECORD_LENGTH = 3'd4;

	// width of the count registers
	localparam int unsigned CNT_W = 13;

endpackage

`default_nettype wire

// ===== design/record_trim_and_pad.sv =====
// ----------------------------------------------------------------------------
// record_trim_and_pad
// trims records to a head, tail or middle window, or pads them with zeros or
// repeats of the edge sample
// ----------------------------------------------------------------------------
// Samples stream in one item per cycle on the s_ group while s_tready is high
// and come out on the m_ group. A position counter tracks where each sample
// sits in its record of record_length samples; operation and region select
// cut, leave, zero fill or extrapolate, and the settings are checked against
// the record length. On a bad setting every sample passes unchanged with a
// nonzero status in m_tuser. m_tlast marks the last sample of each output
// record. Each input item is turned into a plan (head pads, the sample itself,
// tail pads) in the cycle it is accepted; one output register then sends that
// plan out one item per cycle while m_tready allows it. A first sample with
// head pads comes out after them and a last sample with tail pads before them;
// in a one-sample record padded on both sides the sample sits between both.
// Dropped samples leave no gap at the output and are accepted at one per
// cycle. The next item is accepted in the cycle the current plan emits its
// final result.
// Configuration writes are always accepted and must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module record_trim_and_pad #(
	parameter int unsigned MAX_RECORD   = 4096,
	parameter int unsigned MAX_PAD      = 31,
	parameter int unsigned SAMPLE_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [12:0]         cfg_data,
	// sample input
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// real_sample, imag_sample, magnitude_sample, zero fill
	input  wire logic [((3*SAMPLE_WIDTH-1+7)/8)*8-1:0] s_tdata,
	// sample output
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// out_real, out_imag, out_magnitude, zero fill
	output logic [((3*SAMPLE_WIDTH-1+7)/8)*8-1:0] m_tdata,
	output logic                     m_tlast,   // record_end
	output logic [2:0]               m_tuser    // status
);

	localparam int unsigned SW    = SAMPLE_WIDTH;
	localparam int unsigned DW    = 3 * SW - 1;
	localparam int unsigned TDW   = ((DW + 7) / 8) * 8;
	localparam int unsigned CW    = rtp_pkg::CNT_W;
	localparam int unsigned PW    = $clog2(MAX_RECORD);
	localparam int unsigned PADW  = $clog2(MAX_PAD + 1);
	// longest usable record: the length register cannot go beyond its width
	localparam int unsigned LIMIT = (MAX_RECORD > 8191) ? 8191 : MAX_RECORD;
	localparam logic [CW-1:0] MAX_LEN  = CW'(LIMIT);
	localparam logic [CW-1:0] PAD_LIM  = CW'(MAX_PAD);

	// configuration registers
	logic [2:0]    operation_q;
	logic [1:0]    region_q;
	logic [CW-1:0] head_points_q;
	logic [CW-1:0] tail_points_q;
	logic [CW-1:0] record_length_q;

	logic [PW-1:0] pos_q;

	// planned item (stage 1)
	logic              valid_s1;
	logic [SW-1:0]     real_s1;
	logic [SW-1:0]     imag_s1;
	logic [SW-2:0]     mag_s1;
	logic [PADW-1:0]   hpad_s1;
	logic              keep_s1;
	logic              keep_end_s1;
	logic [PADW-1:0]   tpad_s1;
	logic              repeat_s1;
	logic [2:0]        status_s1;

	// output register (stage 2)
	logic              valid_s2;
	logic [DW-1:0]     data_s2;
	logic              last_s2;
	logic [2:0]        user_s2;

	// ------------------------------------------------------------------------
	// configuration port, always ready
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q     <= rtp_pkg::OP_UNDEFINED;
			region_q        <= rtp_pkg::RG_UNDEFINED;
			head_points_q   <= '0;
			tail_points_q   <= '0;
			record_length_q <= CW'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				rtp_pkg::REG_OPERATION:     operation_q     <= cfg_data[2:0];
				rtp_pkg::REG_REGION:        region_q        <= cfg_data[1:0];
				rtp_pkg::REG_HEAD_POINTS:   head_points_q   <= cfg_data;
				rtp_pkg::REG_TAIL_POINTS:   tail_points_q   <= cfg_data;
				rtp_pkg::REG_RECORD_LENGTH: record_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// settings check and window / pad decode
	// ------------------------------------------------------------------------
	logic [CW-1:0] len;
	logic [CW-1:0] len_m1;
	logic [CW:0]   hsum;
	logic [CW-1:0] lo;
	logic [CW-1:0] hi;
	logic [CW-1:0] hpad_cfg;
	logic [CW-1:0] tpad_cfg;
	logic [2:0]    st;

	always_comb begin
		if (record_length_q == '0)
			len = CW'(1);
		else if (record_length_q > MAX_LEN)
			len = MAX_LEN;
		else
			len = record_length_q;
		len_m1 = len - CW'(1);
		hsum   = {1'b0, head_points_q} + {1'b0, tail_points_q};

		lo       = '0;
		hi       = len;
		hpad_cfg = '0;
		tpad_cfg = '0;
		st       = rtp_pkg::ST_OK;

		if (operation_q > rtp_pkg::OP_EXTRAPOLATE || region_q == rtp_pkg::RG_UNDEFINED) begin
			st = rtp_pkg::ST_UNDEF_OP;
		end else begin
			case (operation_q)
				rtp_pkg::OP_CUT: begin
					case (region_q)
						rtp_pkg::RG_HEAD: begin
							if (head_points_q == '0) st = rtp_pkg::ST_NOTHING;
							else if (head_points_q > len_m1) st = rtp_pkg::ST_TOO_MANY;
							else lo = head_points_q;
						end
						rtp_pkg::RG_TAIL: begin
							if (tail_points_q == '0) st = rtp_pkg::ST_NOTHING;
							else if (tail_points_q > len_m1) st = rtp_pkg::ST_TOO_MANY;
							else hi = len - tail_points_q;
						end
						default: begin
							if (hsum == '0) st = rtp_pkg::ST_NOTHING;
							else if (hsum > {1'b0, len_m1}) st = rtp_pkg::ST_TOO_MANY;
							else begin
								lo = head_points_q;
								hi = len - tail_points_q;
							end
						end
					endcase
				end
				rtp_pkg::OP_LEAVE: begin
					case (region_q)
						rtp_pkg::RG_HEAD: begin
							if (head_points_q == len) st = rtp_pkg::ST_NOTHING;
							else if (head_points_q == '0 || head_points_q > len)
								st = rtp_pkg::ST_TOO_MANY;
							else hi = head_points_q;
						end
						rtp_pkg::RG_TAIL: begin
							if (tail_points_q == len) st = rtp_pkg::ST_NOTHING;
							else if (tail_points_q == '0 || tail_points_q > len)
								st = rtp_pkg::ST_TOO_MANY;
							else lo = len - tail_points_q;
						end
						default: begin
							if (hsum == '0) st = rtp_pkg::ST_NOTHING;
							else if (head_points_q > tail_points_q)
								st = rtp_pkg::ST_HEAD_GT_TAIL;
							else if (head_points_q > len_m1 || tail_points_q > len_m1 ||
									head_points_q == tail_points_q)
								st = rtp_pkg::ST_TOO_MANY;
							else begin
								lo = head_points_q;
								hi = tail_points_q;
							end
						end
					endcase
				end
				default: begin
					// zero fill and extrapolate
					case (region_q)
						rtp_pkg::RG_HEAD: begin
							if (head_points_q == '0) st = rtp_pkg::ST_NOTHING;
							else if (head_points_q > PAD_LIM) st = rtp_pkg::ST_PAD_TOO_LONG;
							else hpad_cfg = head_points_q;
						end
						rtp_pkg::RG_TAIL: begin
							if (tail_points_q == '0) st = rtp_pkg::ST_NOTHING;
							else if (tail_points_q > PAD_LIM) st = rtp_pkg::ST_PAD_TOO_LONG;
							else tpad_cfg = tail_points_q;
						end
						default: begin
							if (hsum == '0) st = rtp_pkg::ST_NOTHING;
							else if (head_points_q > PAD_LIM || tail_points_q > PAD_LIM)
								st = rtp_pkg::ST_PAD_TOO_LONG;
							else begin
								hpad_cfg = head_points_q;
								tpad_cfg = tail_points_q;
							end
						end
					endcase
				end
			endcase
		end

		// any error passes the record through untouched
		if (st != rtp_pkg::ST_OK) begin
			lo       = '0;
			hi       = len;
			hpad_cfg = '0;
			tpad_cfg = '0;
		end
	end

	// ------------------------------------------------------------------------
	// per-sample plan from the current position
	// ------------------------------------------------------------------------
	logic [CW-1:0]   pos;
	logic [CW-1:0]   pos_inc;
	logic [PW-1:0]   pos_next;
	logic [PADW-1:0] plan_hpad;
	logic [PADW-1:0] plan_tpad;
	logic            plan_keep;
	logic            plan_keep_end;
	logic            plan_any;

	always_comb begin
		// restart if the record was shortened under the counter
		pos = (CW'(pos_q) >= len) ? '0 : CW'(pos_q);
		pos_inc = pos + CW'(1);
		pos_next = (pos_inc >= len) ? '0 : PW'(pos_inc);

		plan_hpad     = (pos == '0) ? PADW'(hpad_cfg) : '0;
		plan_tpad     = (pos == len_m1) ? PADW'(tpad_cfg) : '0;
		plan_keep     = (pos >= lo) && (pos < hi);
		plan_keep_end = (pos == hi - CW'(1)) && (tpad_cfg == '0);
		plan_any      = (plan_hpad != '0) || plan_keep || (plan_tpad != '0);
	end

	// ------------------------------------------------------------------------
	// emitter: head pads, then the sample, then tail pads
	// ------------------------------------------------------------------------
	logic            out_load;
	logic            item_done;
	logic            s_accept;
	logic [PADW-1:0] hpad_n;
	logic            keep_n;
	logic [PADW-1:0] tpad_n;
	logic            emit_sample;
	logic            emit_last;
	logic [DW-1:0]   emit_data;

	always_comb begin
		hpad_n      = hpad_s1;
		keep_n      = keep_s1;
		tpad_n      = tpad_s1;
		emit_sample = repeat_s1;
		emit_last   = 1'b0;
		if (hpad_s1 != '0) begin
			hpad_n = hpad_s1 - PADW'(1);
		end else if (keep_s1) begin
			keep_n      = 1'b0;
			emit_sample = 1'b1;
			emit_last   = keep_end_s1;
		end else begin
			tpad_n    = tpad_s1 - PADW'(1);
			emit_last = (tpad_s1 == PADW'(1));
		end
		item_done = (hpad_n == '0) && !keep_n && (tpad_n == '0);
		emit_data = emit_sample ? {mag_s1, imag_s1, real_s1} : '0;
	end

	assign out_load = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || (out_load && item_done);
	assign s_accept = s_tvalid && s_tready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_accept) begin
				pos_q    <= pos_next;
				valid_s1 <= plan_any;
			end else if (out_load && item_done) begin
				valid_s1 <= 1'b0;
			end
			if (out_load)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	// payload and plan counters
	always_ff @(posedge clk) begin
		if (s_accept) begin
			real_s1     <= s_tdata[SW-1:0];
			imag_s1     <= s_tdata[2*SW-1:SW];
			mag_s1      <= s_tdata[3*SW-2:2*SW];
			hpad_s1     <= plan_hpad;
			keep_s1     <= plan_keep;
			keep_end_s1 <= plan_keep_end;
			tpad_s1     <= plan_tpad;
			repeat_s1   <= (operation_q == rtp_pkg::OP_EXTRAPOLATE);
			status_s1   <= st;
		end else if (out_load) begin
			hpad_s1 <= hpad_n;
			keep_s1 <= keep_n;
			tpad_s1 <= tpad_n;
		end
		if (out_load) begin
			data_s2 <= emit_data;
			last_s2 <= emit_last;
			user_s2 <= status_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = TDW'(data_s2);
	assign m_tlast  = last_s2;
	assign m_tuser  = user_s2;

endmodule

`default_nettype wire

// ===== bench/rtp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_checker: output predictor and scoreboard for record_trim_and_pad
// Follows every configuration write and every accepted input sample. It works
// out the trimmed or padded output items with their status and record end,
// then compares each output item, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module rtp_checker #(
	parameter int DATA_W = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [12:0]       cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	// real_sample, imag_sample, magnitude_sample, zero fill
	input  logic [DATA_W-1:0] s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	// out_real, out_imag, out_magnitude, zero fill
	input  logic [DATA_W-1:0] m_tdata,
	input  logic              m_tlast,
	input  logic [2:0]        m_tuser,
	output int                errors,
	output int                results,
	output int                pending
);
	import rtp_pkg::*;

	localparam int MAX_RECORD = 4096;
	localparam int MAX_PAD    = 31;
	localparam int SHOW_LIMIT = 30;
	localparam logic [2:0] OP_AT_RESET = 3'd4;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [30:0] mg;
		logic        last;
		logic [2:0]  st;
	} emitted_t;

	emitted_t expected_samples[$];
	emitted_t want;

	logic [2:0]  op_reg;
	logic [1:0]  region_reg;
	logic [12:0] head_reg;
	logic [12:0] tail_reg;
	logic [12:0] len_reg;
	int          position;

	initial begin
		errors  = 0;
		results = 0;
	end

	task automatic report(input string msg);
		errors++;
		if (errors <= SHOW_LIMIT)
			$display("%t: output item %0d: %s", $realtime, results, msg);
	endtask

	function automatic emitted_t make_item(input logic [31:0] re, input logic [31:0] im,
		input logic [30:0] mg, input logic last, input logic [2:0] st);
		emitted_t e;
		e.re   = re;
		e.im   = im;
		e.mg   = mg;
		e.last = last;
		e.st   = st;
		return e;
	endfunction

	// settings are checked on every sample, so a change acts on the next one
	task automatic predict_samples(input logic [31:0] re, input logic [31:0] im,
		input logic [30:0] mg);
		int         len;
		int         h;
		int         t;
		int         lo;
		int         hi;
		int         hpad;
		int         tpad;
		int         pos;
		int         k;
		logic [2:0] st;
		bit         copy_edge;
		len = int'(len_reg);
		if (len == 0) len = 1;
		if (len > MAX_RECORD) len = MAX_RECORD;
		// record length shrank under the current position
		if (position >= len) position = 0;
		pos = position;
		h = int'(head_reg);
		t = int'(tail_reg);
		lo = 0;
		hi = len;
		hpad = 0;
		tpad = 0;
		st = ST_OK;
		copy_edge = (op_reg == OP_EXTRAPOLATE);

		if (op_reg > OP_EXTRAPOLATE || region_reg == RG_UNDEFINED) begin
			st = ST_UNDEF_OP;
		end else begin
			case (op_reg)
			OP_CUT: begin
				case (region_reg)
				RG_HEAD: begin
					if (h == 0) st = ST_NOTHING;
					else if (h > len - 1) st = ST_TOO_MANY;
					else lo = h;
				end
				RG_TAIL: begin
					if (t == 0) st = ST_NOTHING;
					else if (t > len - 1) st = ST_TOO_MANY;
					else hi = len - t;
				end
				default: begin
					if (h + t == 0) st = ST_NOTHING;
					else if (h + t > len - 1) st = ST_TOO_MANY;
					else begin
						lo = h;
						hi = len - t;
					end
				end
				endcase
			end
			OP_LEAVE: begin
				case (region_reg)
				RG_HEAD: begin
					if (h == len) st = ST_NOTHING;
					else if (h < 1 || h > len) st = ST_TOO_MANY;
					else hi = h;
				end
				RG_TAIL: begin
					if (t == len) st = ST_NOTHING;
					else if (t < 1 || t > len) st = ST_TOO_MANY;
					else lo = len - t;
				end
				default: begin
					// middle window from head_points up to tail_points, exclusive
					if (h + t == 0) st = ST_NOTHING;
					else if (h > t) st = ST_HEAD_GT_TAIL;
					else if (h > len - 1 || t > len - 1 || h == t) st = ST_TOO_MANY;
					else begin
						lo = h;
						hi = t;
					end
				end
				endcase
			end
			default: begin
				// zero fill and extrapolate share the pad count checks
				case (region_reg)
				RG_HEAD: begin
					if (h == 0) st = ST_NOTHING;
					else if (h > MAX_PAD) st = ST_PAD_TOO_LONG;
					else hpad = h;
				end
				RG_TAIL: begin
					if (t == 0) st = ST_NOTHING;
					else if (t > MAX_PAD) st = ST_PAD_TOO_LONG;
					else tpad = t;
				end
				default: begin
					if (h + t == 0) st = ST_NOTHING;
					else if (h > MAX_PAD || t > MAX_PAD) st = ST_PAD_TOO_LONG;
					else begin
						hpad = h;
						tpad = t;
					end
				end
				endcase
			end
			endcase
		end

		// any bad setting: plain pass through of the input record
		if (st != ST_OK) begin
			lo = 0;
			hi = len;
			hpad = 0;
			tpad = 0;
		end

		if (pos == 0) begin
			for (k = 0; k < hpad; k++)
				expected_samples.push_back(copy_edge ? make_item(re, im, mg, 1'b0, st)
					: make_item('0, '0, '0, 1'b0, st));
		end
		if (pos >= lo && pos < hi)
			expected_samples.push_back(make_item(re, im, mg, pos == hi - 1 && tpad == 0, st));
		if (pos == len - 1) begin
			for (k = 0; k < tpad; k++)
				expected_samples.push_back(copy_edge ? make_item(re, im, mg, k == tpad - 1, st)
					: make_item('0, '0, '0, k == tpad - 1, st));
		end

		position = (pos + 1 >= len) ? 0 : pos + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_reg     = OP_AT_RESET;
			region_reg = RG_UNDEFINED;
			head_reg   = '0;
			tail_reg   = '0;
			len_reg    = 13'd1;
			position   = 0;
			expected_samples.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_OPERATION:     op_reg     = cfg_data[2:0];
				REG_REGION:        region_reg = cfg_data[1:0];
				REG_HEAD_POINTS:   head_reg   = cfg_data;
				REG_TAIL_POINTS:   tail_reg   = cfg_data;
				REG_RECORD_LENGTH: len_reg    = cfg_data;
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_samples(s_tdata[31:0], s_tdata[63:32], s_tdata[94:64]);
			if (m_tvalid && m_tready) begin
				if (expected_samples.size() == 0) begin
					report($sformatf("unexpected output item, tdata %h last %b status %0d",
						m_tdata, m_tlast, m_tuser));
				end else begin
					want = expected_samples.pop_front();
					if (m_tdata[31:0] !== want.re)
						report($sformatf("out_real %h, expected %h", m_tdata[31:0], want.re));
					if (m_tdata[63:32] !== want.im)
						report($sformatf("out_imag %h, expected %h", m_tdata[63:32], want.im));
					if (m_tdata[94:64] !== want.mg)
						report($sformatf("out_magnitude %h, expected %h",
							m_tdata[94:64], want.mg));
					if (m_tlast !== want.last)
						report($sformatf("record_end %b, expected %b", m_tlast, want.last));
					if (m_tuser !== want.st)
						report($sformatf("status %0d, expected %0d", m_tuser, want.st));
				end
				results++;
			end
			pending <= expected_samples.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for record_trim_and_pad
// Drives sample records through every operation and region, first with a short
// directed set (length zero and clamping, bad settings, pads at their limits,
// one-sided cuts, middle windows), then random settings with random records.
// Both stream sides idle and stall at random. The checker beside the block
// predicts and compares; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import rtp_pkg::*;

	localparam int DATA_W        = 96;
	localparam int MAX_RECORD    = 4096;
	localparam int MAX_PAD       = 31;
	localparam int RANDOM_ITEMS  = 320;
	localparam int IDLE_PCT      = 7;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;
	// operation code beyond the supported ones, and a register index with no register
	localparam logic [2:0] OP_UNSUPPORTED = 3'd7;
	localparam logic [2:0] REG_SPARE      = 3'd7;

	typedef struct {
		logic [2:0] op;
		logic [1:0] rg;
		int         h;
		int         t;
		int         len;
		int         items;
	} settings_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [2:0]        cfg_index;
	logic [12:0]       cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;    // real_sample, imag_sample, magnitude_sample, zero fill
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;    // out_real, out_imag, out_magnitude, zero fill
	logic              m_tlast;    // record_end
	logic [2:0]        m_tuser;    // status

	int errors;
	int results;
	int pending;

	// steady switches idling off on both sides for a stretch of the run
	logic steady;
	int   cycle_count = 0;
	int   samples_sent = 0;
	int   phase_count = 0;
	int   op_phases[4] = '{0, 0, 0, 0};
	int   odd_op_phases = 0;

	record_trim_and_pad uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	rtp_checker #(.DATA_W(DATA_W)) results_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.errors    (errors),
		.results   (results),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output side stalls at random, with a chance of about 7 in a hundred
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d output items still expected",
				cycle_count, pending);
			$display("record_trim_and_pad regression: fail");
			$finish;
		end
	end

	// sample part with its extremes weighted in
	function automatic logic [31:0] pick_part();
		case ($urandom_range(0, 9))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] make_sample();
		logic [31:0] re;
		logic [31:0] im;
		logic [30:0] mg;
		re = pick_part();
		im = pick_part();
		case ($urandom_range(0, 9))
		0: mg = '0;
		1: mg = '1;
		default: mg = 31'($urandom);
		endcase
		return {1'b0, mg, im, re};
	endfunction

	// mostly settings that get past the checks, some out of range, a few wild
	function automatic settings_t pick_settings();
		settings_t s;
		int        r;
		int        le;
		r = $urandom_range(0, 99);
		s.op = 3'((r < 8) ? $urandom_range(OP_EXTRAPOLATE + 1, OP_UNSUPPORTED)
			: $urandom_range(OP_CUT, OP_EXTRAPOLATE));
		r = $urandom_range(0, 99);
		s.rg = 2'((r < 8) ? RG_UNDEFINED : $urandom_range(RG_HEAD, RG_BOTH));

		r = $urandom_range(0, 99);
		if (r < 3) s.len = 0;
		else if (r < 5) s.len = $urandom_range(MAX_RECORD + 1, 8191);
		else if (r < 7) s.len = MAX_RECORD;
		else if (r < 22) s.len = $urandom_range(9, 64);
		else s.len = $urandom_range(1, 8);
		le = (s.len == 0) ? 1 : (s.len > MAX_RECORD ? MAX_RECORD : s.len);

		r = $urandom_range(0, 99);
		s.h = 0;
		s.t = 0;
		if (r < 72) begin
			case (s.op)
			OP_CUT: begin
				s.h = $urandom_range(0, le - 1);
				s.t = $urandom_range(0, le - 1 - s.h);
			end
			OP_LEAVE: begin
				if (s.rg == RG_BOTH) begin
					if (le >= 2) begin
						s.t = $urandom_range(1, le - 1);
						s.h = $urandom_range(0, s.t - 1);
					end
				end else begin
					s.h = $urandom_range(1, le);
					s.t = $urandom_range(1, le);
				end
			end
			OP_ZERO_FILL, OP_EXTRAPOLATE: begin
				s.h = $urandom_range(0, MAX_PAD);
				s.t = $urandom_range(0, MAX_PAD);
			end
			default: begin
				s.h = $urandom_range(0, le);
				s.t = $urandom_range(0, le);
			end
			endcase
		end else if (r < 92) begin
			if (s.op == OP_ZERO_FILL || s.op == OP_EXTRAPOLATE) begin
				s.h = $urandom_range(0, MAX_PAD + 3);
				s.t = $urandom_range(0, MAX_PAD + 3);
			end else begin
				s.h = $urandom_range(0, le + 2);
				s.t = $urandom_range(0, le + 2);
			end
		end else begin
			s.h = $urandom_range(0, 8191);
			s.t = $urandom_range(0, 8191);
		end

		// one to two records plus a stray sample or two; long records only in part
		s.items = le * $urandom_range(1, 2) + $urandom_range(0, 2);
		if (s.items > 40) s.items = $urandom_range(20, 40);
		return s;
	endfunction

	task automatic push_sample(input logic [DATA_W-1:0] word);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		samples_sent++;
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input logic [2:0] index, input logic [12:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// stop sending, let every expected item come out, then give dropped
	// samples still in flight time to clear
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [2:0] op, input logic [1:0] rg, input int h,
		input int t, input int len, input int n, input int pause_at);
		logic [12:0] junk;
		logic [12:0] spare_data;
		int          i;
		wait_quiet();
		// upper bits of the narrow registers are sometimes set and must be dropped
		junk = 13'($urandom);
		if ($urandom_range(0, 3) != 0) junk = '0;
		spare_data = 13'($urandom);
		write_reg(REG_OPERATION, {junk[12:3], op});
		write_reg(REG_REGION, {junk[12:2], rg});
		write_reg(REG_HEAD_POINTS, h[12:0]);
		write_reg(REG_TAIL_POINTS, t[12:0]);
		write_reg(REG_RECORD_LENGTH, len[12:0]);
		// an index with no register behind it changes nothing
		if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, spare_data);
		cfg_valid <= 1'b0;
		phase_count++;
		if (op > OP_EXTRAPOLATE) odd_op_phases++;
		else op_phases[op]++;
		for (i = 0; i < n; i++) begin
			if (i == pause_at) wait_quiet();
			push_sample(make_sample());
		end
	endtask

	initial begin : stimulus
		settings_t s;
		int        random_sent;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		steady    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings are an undefined operation: plain pass through
		push_sample({1'b0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
		push_sample({1'b0, 31'h0, 32'h8000_0000, 32'hFFFF_FFFF});

		// length zero counts as one: head pads, the sample, tail pads every time
		run_phase(OP_ZERO_FILL, RG_BOTH, 2, 1, 0, 1, -1);
		// length clamped to the maximum, so keeping 4096 samples is nothing to do
		run_phase(OP_LEAVE, RG_HEAD, MAX_RECORD, 0, 8191, 2, -1);
		// shorter length puts the position past the end; only the tail is cut
		run_phase(OP_CUT, RG_BOTH, 0, 1, 2, 2, -1);
		// longest pads on both sides, repeating the edge samples
		run_phase(OP_EXTRAPOLATE, RG_BOTH, MAX_PAD, MAX_PAD, 2, 2, -1);
		// middle window starting at zero keeps the first samples
		run_phase(OP_LEAVE, RG_BOTH, 0, 2, 3, 3, -1);
		// window start beyond its end
		run_phase(OP_LEAVE, RG_BOTH, 2, 1, 3, 1, -1);
		// pad one beyond the longest allowed
		run_phase(OP_ZERO_FILL, RG_HEAD, MAX_PAD + 1, 0, 1, 1, -1);
		// counts at their full register range
		run_phase(OP_CUT, RG_HEAD, 8191, 8191, 3, 1, -1);
		run_phase(OP_UNSUPPORTED, RG_TAIL, 5, 5, 3, 1, -1);
		run_phase(OP_CUT, RG_UNDEFINED, 1, 1, 3, 1, -1);
		run_phase(OP_CUT, RG_TAIL, 0, 0, 3, 1, -1);
		run_phase(OP_LEAVE, RG_TAIL, 0, 1, 3, 3, -1);
		run_phase(OP_ZERO_FILL, RG_TAIL, 0, 3, 2, 2, -1);

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			s = pick_settings();
			steady <= (random_sent >= 100 && random_sent < 190);
			// one phase halts halfway until the output has caught up
			run_phase(s.op, s.rg, s.h, s.t, s.len, s.items,
				(phase_count == 20) ? s.items / 2 : -1);
			random_sent += s.items;
		end

		steady <= 1'b0;
		wait_quiet();

		$display("%0d samples sent under %0d settings, %0d output items checked",
			samples_sent, phase_count, results);
		$display("phases: cut %0d, leave %0d, zero fill %0d, extrapolate %0d, other %0d",
			op_phases[OP_CUT], op_phases[OP_LEAVE], op_phases[OP_ZERO_FILL],
			op_phases[OP_EXTRAPOLATE], odd_op_phases);
		if (errors == 0)
			$display("record_trim_and_pad regression: pass");
		else
			$display("record_trim_and_pad regression: fail");
		$finish;
	end

endmodule
